// ===== rtl/core/bale_pkg.sv =====
// Shared types, codes and constants of the bounded array list engine.
package bale_pkg;

    localparam int CAPACITY_DEF = 8;
    localparam int WORD_W       = 32;
    localparam int POS_W        = 3;
    localparam int AMT_W        = 16;
    localparam int AMT_STEP_W   = $clog2(AMT_W + 1);
    localparam int FIDX_W       = 3;
    localparam int FILL_W       = 4;

    typedef logic signed [WORD_W-1:0] word_t;

    typedef enum logic [2:0] {
        CMD_INS_FRONT,
        CMD_INS_END,
        CMD_INS_AT,
        CMD_DEL_FRONT,
        CMD_DEL_END,
        CMD_DEL_AT,
        CMD_SEARCH,
        CMD_ROTATE
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK,
        ST_FULL,
        ST_EMPTY,
        ST_NOT_FOUND,
        ST_BAD_INDEX
    } status_t;

    typedef enum logic [1:0] {
        SW_NONE,
        SW_INSERT,
        SW_DELETE,
        SW_SEARCH
    } sweep_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SWEEP,
        S_MOD,
        S_ROT,
        S_FINISH
    } state_t;

    typedef struct packed {
        cmd_t              command;
        word_t             data_word;
        logic [POS_W-1:0]  position;
        logic [AMT_W-1:0]  rotate_amount;
    } cmd_item_t;

    typedef struct packed {
        status_t           status;
        word_t             element_out;
        logic [FIDX_W-1:0] found_index;
        logic [FILL_W-1:0] fill_count;
    } res_item_t;

    typedef struct packed {
        sweep_t kind;
        logic   rot_en;
        word_t  data;
    } cell_ctl_t;

    typedef struct packed {
        word_t word;
        logic  hit;
    } carry_t;

endpackage

// ===== rtl/core/bale_cell.sv =====
// One storage cell of the list chain with its travelling token and carry stage.
module bale_cell #(
    parameter int  CAPACITY   = bale_pkg::CAPACITY_DEF,
    parameter int  CELL_INDEX = 0,
    localparam int CNT_W      = $clog2(CAPACITY + 1),
    localparam int IDX_W      = $clog2(CAPACITY)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  bale_pkg::cell_ctl_t ctl,
    input  logic [CNT_W-1:0]    at_idx,
    input  logic [CNT_W-1:0]    count,
    input  logic                tok_in,
    input  bale_pkg::carry_t    carry_in,
    input  logic [IDX_W-1:0]    idx_in,
    input  bale_pkg::word_t     right_word,
    input  bale_pkg::word_t     head_word,
    output bale_pkg::word_t     word,
    output logic                tok_out,
    output bale_pkg::carry_t    carry_out,
    output logic [IDX_W-1:0]    idx_out
);

    localparam logic [CNT_W-1:0] POS      = CNT_W'(CELL_INDEX);
    localparam logic [CNT_W-1:0] POS_NEXT = CNT_W'(CELL_INDEX + 1);
    localparam logic [IDX_W-1:0] IDX      = IDX_W'(CELL_INDEX);

    bale_pkg::word_t  word_reg;
    bale_pkg::word_t  word_next;
    logic             tok_reg;
    bale_pkg::carry_t carry_reg;
    bale_pkg::carry_t carry_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;

    always_comb
    begin
        word_next  = word_reg;
        carry_next = carry_in;
        idx_next   = idx_in;
        if (tok_in)
        begin
            case (ctl.kind)
                bale_pkg::SW_INSERT:
                begin
                    if (POS == at_idx)
                    begin
                        word_next       = ctl.data;
                        carry_next.word = word_reg;
                    end
                    else if (POS > at_idx && POS <= count)
                    begin
                        word_next       = carry_in.word;
                        carry_next.word = word_reg;
                    end
                end
                bale_pkg::SW_DELETE:
                begin
                    if (POS == at_idx)
                    begin
                        carry_next.word = word_reg;
                    end
                    if (POS >= at_idx && POS_NEXT < count)
                    begin
                        word_next = right_word;
                    end
                end
                bale_pkg::SW_SEARCH:
                begin
                    if (POS < count && word_reg == ctl.data)
                    begin
                        carry_next.hit = 1'b1;
                        idx_next       = IDX;
                    end
                end
                default:
                begin
                    word_next = word_reg;
                end
            endcase
        end
        if (ctl.rot_en)
        begin
            if (POS_NEXT < count)
            begin
                word_next = right_word;
            end
            else if (POS_NEXT == count)
            begin
                word_next = head_word;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= 1'b0;
        end
        else
        begin
            tok_reg <= tok_in;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg  <= word_next;
        carry_reg <= carry_next;
        idx_reg   <= idx_next;
    end

    assign word      = word_reg;
    assign tok_out   = tok_reg;
    assign carry_out = carry_reg;
    assign idx_out   = idx_reg;

endmodule

// ===== rtl/core/bale_mod.sv =====
// Bit-serial restoring remainder unit for the rotate amount.
module bale_mod #(
    parameter int DIV_W = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [bale_pkg::AMT_W-1:0] dividend,
    input  logic [DIV_W-1:0]           divisor,
    output logic                       done,
    output logic [DIV_W-1:0]           rem
);

    logic                            busy_reg;
    logic                            busy_next;
    logic                            done_reg;
    logic                            done_next;
    logic [DIV_W-1:0]                rem_reg;
    logic [DIV_W-1:0]                rem_next;
    logic [bale_pkg::AMT_W-1:0]      shf_reg;
    logic [bale_pkg::AMT_W-1:0]      shf_next;
    logic [bale_pkg::AMT_STEP_W-1:0] cnt_reg;
    logic [bale_pkg::AMT_STEP_W-1:0] cnt_next;
    logic [DIV_W:0]                  trial;
    logic [DIV_W:0]                  diff;

    always_comb
    begin
        trial     = {rem_reg, shf_reg[bale_pkg::AMT_W-1]};
        diff      = trial - {1'b0, divisor};
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        shf_next  = shf_reg;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            rem_next  = '0;
            shf_next  = dividend;
            cnt_next  = bale_pkg::AMT_STEP_W'(bale_pkg::AMT_W);
        end
        else if (busy_reg)
        begin
            rem_next = (trial >= {1'b0, divisor}) ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            shf_next = {shf_reg[bale_pkg::AMT_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == bale_pkg::AMT_STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        shf_reg <= shf_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

// ===== rtl/core/bounded_array_list_engine.sv =====
// Top level of the bounded array list engine: command decode, cell chain and result register.
//
// Holds an ordered list of up to CAPACITY signed 32-bit words in a chain of cells and runs one
// command at a time. Insert, delete and search send a token down the chain, one cell per cycle,
// carrying the displaced or removed word and the search hit along with it. Rotate first reduces
// the amount modulo the count in a 16-step bit-serial remainder unit and then shifts the whole
// list left by one place per cycle, count minus the remainder times (fewer than CAPACITY shifts).
// Rejected commands (full, empty, bad index) skip the chain and go from decode straight to the
// finish state. A result waits in an output register while the next command is accepted. Stored
// words have no reset; the count resets to zero.
module bounded_array_list_engine #(
    parameter int CAPACITY = bale_pkg::CAPACITY_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  bale_pkg::cmd_item_t cmd_data,
    output logic                res_valid,
    input  logic                res_stall,
    output bale_pkg::res_item_t res_data
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CW    = (CNT_W > bale_pkg::POS_W) ? CNT_W : bale_pkg::POS_W;

    bale_pkg::state_t                 state_reg;
    bale_pkg::state_t                 state_next;
    bale_pkg::sweep_t                 kind_reg;
    bale_pkg::sweep_t                 kind_next;
    logic                             start_reg;
    logic                             start_next;
    logic [CNT_W-1:0]                 at_reg;
    logic [CNT_W-1:0]                 at_next;
    logic [CNT_W-1:0]                 count_reg;
    logic [CNT_W-1:0]                 count_next;
    logic [CNT_W-1:0]                 steps_reg;
    logic [CNT_W-1:0]                 steps_next;
    bale_pkg::status_t                status_reg;
    bale_pkg::status_t                status_next;
    bale_pkg::word_t                  elem_reg;
    bale_pkg::word_t                  elem_next;
    logic [bale_pkg::FIDX_W-1:0]      fidx_reg;
    logic [bale_pkg::FIDX_W-1:0]      fidx_next;
    bale_pkg::cmd_t                   cmd_reg;
    bale_pkg::word_t                  data_reg;
    logic [bale_pkg::POS_W-1:0]       pos_reg;
    logic [bale_pkg::AMT_W-1:0]       amt_reg;
    logic                             res_valid_reg;
    logic                             res_valid_next;
    bale_pkg::res_item_t              res_data_reg;
    bale_pkg::res_item_t              res_data_next;

    logic                             accept;
    logic                             mod_start;
    logic                             mod_done;
    logic [CNT_W-1:0]                 mod_rem;
    logic [CW-1:0]                    pos_w;
    logic [CW-1:0]                    cnt_w;
    logic [CW-1:0]                    at_w;
    logic                             full;
    bale_pkg::cell_ctl_t              ctl;

    bale_pkg::word_t                  word_w  [CAPACITY];
    logic                             tok_w   [CAPACITY];
    bale_pkg::carry_t                 carry_w [CAPACITY];
    logic [IDX_W-1:0]                 idx_w   [CAPACITY];

    assign accept    = cmd_valid && !cmd_stall;
    assign cmd_stall = (state_reg != bale_pkg::S_IDLE);
    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    assign pos_w = CW'(pos_reg);
    assign cnt_w = CW'(count_reg);
    assign full  = (count_reg == CNT_W'(CAPACITY));

    always_comb
    begin
        case (cmd_reg)
            bale_pkg::CMD_INS_FRONT: at_w = '0;
            bale_pkg::CMD_DEL_FRONT: at_w = '0;
            bale_pkg::CMD_INS_END:   at_w = cnt_w;
            bale_pkg::CMD_DEL_END:   at_w = cnt_w - 1'b1;
            default:                 at_w = pos_w;
        endcase
    end

    assign mod_start = (state_reg == bale_pkg::S_DECODE) && (cmd_reg == bale_pkg::CMD_ROTATE)
                       && (count_reg != '0);

    assign ctl.kind   = kind_reg;
    assign ctl.rot_en = (state_reg == bale_pkg::S_ROT) && (steps_reg != '0);
    assign ctl.data   = data_reg;

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        start_next     = 1'b0;
        at_next        = at_reg;
        count_next     = count_reg;
        steps_next     = steps_reg;
        status_next    = status_reg;
        elem_next      = elem_reg;
        fidx_next      = fidx_reg;
        res_valid_next = res_valid_reg;
        res_data_next  = res_data_reg;

        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            bale_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    status_next = bale_pkg::ST_OK;
                    elem_next   = '0;
                    fidx_next   = '0;
                    state_next  = bale_pkg::S_DECODE;
                end
            end
            bale_pkg::S_DECODE:
            begin
                at_next = CNT_W'(at_w);
                case (cmd_reg)
                    bale_pkg::CMD_INS_FRONT, bale_pkg::CMD_INS_END, bale_pkg::CMD_INS_AT:
                    begin
                        if (full)
                        begin
                            status_next = bale_pkg::ST_FULL;
                            state_next  = bale_pkg::S_FINISH;
                        end
                        else if (at_w > cnt_w)
                        begin
                            status_next = bale_pkg::ST_BAD_INDEX;
                            state_next  = bale_pkg::S_FINISH;
                        end
                        else
                        begin
                            kind_next  = bale_pkg::SW_INSERT;
                            start_next = 1'b1;
                            state_next = bale_pkg::S_SWEEP;
                        end
                    end
                    bale_pkg::CMD_DEL_FRONT, bale_pkg::CMD_DEL_END, bale_pkg::CMD_DEL_AT:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = bale_pkg::ST_EMPTY;
                            state_next  = bale_pkg::S_FINISH;
                        end
                        else if (at_w >= cnt_w)
                        begin
                            status_next = bale_pkg::ST_BAD_INDEX;
                            state_next  = bale_pkg::S_FINISH;
                        end
                        else
                        begin
                            kind_next  = bale_pkg::SW_DELETE;
                            start_next = 1'b1;
                            state_next = bale_pkg::S_SWEEP;
                        end
                    end
                    bale_pkg::CMD_SEARCH:
                    begin
                        kind_next  = bale_pkg::SW_SEARCH;
                        start_next = 1'b1;
                        state_next = bale_pkg::S_SWEEP;
                    end
                    bale_pkg::CMD_ROTATE:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = bale_pkg::ST_EMPTY;
                            state_next  = bale_pkg::S_FINISH;
                        end
                        else
                        begin
                            state_next = bale_pkg::S_MOD;
                        end
                    end
                    default:
                    begin
                        state_next = bale_pkg::S_FINISH;
                    end
                endcase
            end
            bale_pkg::S_SWEEP:
            begin
                if (tok_w[CAPACITY-1])
                begin
                    case (kind_reg)
                        bale_pkg::SW_INSERT:
                        begin
                            count_next = count_reg + 1'b1;
                        end
                        bale_pkg::SW_DELETE:
                        begin
                            elem_next  = carry_w[CAPACITY-1].word;
                            count_next = count_reg - 1'b1;
                        end
                        bale_pkg::SW_SEARCH:
                        begin
                            if (carry_w[CAPACITY-1].hit)
                            begin
                                fidx_next = bale_pkg::FIDX_W'(idx_w[CAPACITY-1]);
                            end
                            else
                            begin
                                status_next = bale_pkg::ST_NOT_FOUND;
                            end
                        end
                        default:
                        begin
                            status_next = status_reg;
                        end
                    endcase
                    kind_next  = bale_pkg::SW_NONE;
                    state_next = bale_pkg::S_FINISH;
                end
            end
            bale_pkg::S_MOD:
            begin
                if (mod_done)
                begin
                    steps_next = (mod_rem == '0) ? '0 : count_reg - mod_rem;
                    state_next = bale_pkg::S_ROT;
                end
            end
            bale_pkg::S_ROT:
            begin
                if (steps_reg == '0)
                begin
                    state_next = bale_pkg::S_FINISH;
                end
                else
                begin
                    steps_next = steps_reg - 1'b1;
                end
            end
            bale_pkg::S_FINISH:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    res_valid_next            = 1'b1;
                    res_data_next.status      = status_reg;
                    res_data_next.element_out = elem_reg;
                    res_data_next.found_index = fidx_reg;
                    res_data_next.fill_count  = bale_pkg::FILL_W'(count_reg);
                    state_next                = bale_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bale_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bale_pkg::S_IDLE;
            kind_reg      <= bale_pkg::SW_NONE;
            start_reg     <= 1'b0;
            count_reg     <= '0;
            steps_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            start_reg     <= start_next;
            count_reg     <= count_next;
            steps_reg     <= steps_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        at_reg       <= at_next;
        status_reg   <= status_next;
        elem_reg     <= elem_next;
        fidx_reg     <= fidx_next;
        res_data_reg <= res_data_next;
        if (accept)
        begin
            cmd_reg  <= cmd_data.command;
            data_reg <= cmd_data.data_word;
            pos_reg  <= cmd_data.position;
            amt_reg  <= cmd_data.rotate_amount;
        end
    end

    bale_mod #(
        .DIV_W (CNT_W)
    ) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (amt_reg),
        .divisor  (count_reg),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        bale_pkg::word_t  right_word;
        logic             tok_in;
        bale_pkg::carry_t carry_in;
        logic [IDX_W-1:0] idx_in;

        if (g == 0)
        begin : g_head
            assign tok_in   = start_reg;
            assign carry_in = '0;
            assign idx_in   = '0;
        end
        else
        begin : g_link
            assign tok_in   = tok_w[g-1];
            assign carry_in = carry_w[g-1];
            assign idx_in   = idx_w[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_tail
            assign right_word = word_w[g];
        end
        else
        begin : g_body
            assign right_word = word_w[g+1];
        end

        bale_cell #(
            .CAPACITY   (CAPACITY),
            .CELL_INDEX (g)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .at_idx     (at_reg),
            .count      (count_reg),
            .tok_in     (tok_in),
            .carry_in   (carry_in),
            .idx_in     (idx_in),
            .right_word (right_word),
            .head_word  (word_w[0]),
            .word       (word_w[g]),
            .tok_out    (tok_w[g]),
            .carry_out  (carry_w[g]),
            .idx_out    (idx_w[g])
        );
    end

endmodule
